[hdl/sapb_pkg.sv]
package sapb_pkg;

  localparam int CHANNELS_DEF = 6;
  localparam int FRACTION_BITS_DEF = 12;
  localparam int MAX_CHANNELS = 8;

  localparam int CFG_DW = 64;
  localparam int CFG_AW = 6;
  localparam int REG_IDX_W = 3;
  localparam int SET_W = 48;
  localparam int SET_REGS = 6;
  localparam int MASK_W = 6;
  localparam int FIELD_W = 12;

  localparam logic [SET_W-1:0] SETTINGS_RESET = 48'h5DC76C44C19A;
  localparam logic [MASK_W-1:0] MASK_RESET = 6'h3F;
  localparam logic [REG_IDX_W-1:0] REG_MASK = 3'd6;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_INIT = 4'd0;
  localparam logic [OP_W-1:0] OP_INC = 4'd1;
  localparam logic [OP_W-1:0] OP_DEC = 4'd2;
  localparam logic [OP_W-1:0] OP_MIN = 4'd3;
  localparam logic [OP_W-1:0] OP_MAX = 4'd4;
  localparam logic [OP_W-1:0] OP_MIN_TOG = 4'd5;
  localparam logic [OP_W-1:0] OP_MAX_TOG = 4'd6;
  localparam logic [OP_W-1:0] OP_CENTER = 4'd7;
  localparam logic [OP_W-1:0] OP_REFRESH = 4'd8;

  typedef struct packed {
    logic load_cmd;
    logic load_run;
    logic apply;
    logic ptr_next;
    logic div_start;
    logic div_step;
    logic init_write;
    logic mul_load;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic ptr_enabled;
    logic ptr_at_end;
    logic div_done;
  } dp_status_t;

endpackage

[hdl/sapb_regs.sv]
module sapb_regs #(
  parameter int NUM_SLOTS = sapb_pkg::SET_REGS
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [sapb_pkg::CFG_AW-1:0]                 paddr,
  input  logic [sapb_pkg::CFG_DW-1:0]                 pwdata,
  output logic [sapb_pkg::CFG_DW-1:0]                 prdata,
  output logic                                        pready,
  output logic [NUM_SLOTS-1:0][sapb_pkg::SET_W-1:0]   settings,
  output logic [sapb_pkg::MASK_W-1:0]                 enable_mask
);

  logic [NUM_SLOTS-1:0][sapb_pkg::SET_W-1:0] settings_r;
  logic [sapb_pkg::MASK_W-1:0]               mask_r;
  logic [sapb_pkg::REG_IDX_W-1:0]            ridx;
  logic                                      wr;

  assign ridx   = paddr[sapb_pkg::CFG_AW-1:sapb_pkg::CFG_AW-sapb_pkg::REG_IDX_W];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        settings_r[i] <= sapb_pkg::SETTINGS_RESET;
      end
      mask_r <= sapb_pkg::MASK_RESET;
    end else if (wr) begin
      if (ridx == sapb_pkg::REG_MASK) begin
        mask_r <= pwdata[sapb_pkg::MASK_W-1:0];
      end else if (int'(ridx) < sapb_pkg::SET_REGS) begin
        settings_r[ridx] <= pwdata[sapb_pkg::SET_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (ridx)
      sapb_pkg::REG_MASK: begin
        prdata = sapb_pkg::CFG_DW'(mask_r);
      end
      default: begin
        if (int'(ridx) < sapb_pkg::SET_REGS) begin
          prdata = sapb_pkg::CFG_DW'(settings_r[ridx]);
        end
      end
    endcase
  end

  assign settings    = settings_r;
  assign enable_mask = mask_r;

endmodule

[hdl/sapb_ctrl.sv]
module sapb_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sapb_pkg::OP_W-1:0]   in_operation,
  input  sapb_pkg::dp_status_t        status,
  output sapb_pkg::dp_cmd_t           cmd,
  output logic                        busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMD  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       init_r, init_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      init_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    init_nxt  = init_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_operation)
            sapb_pkg::OP_INIT: begin
              cmd.load_run = 1'b1;
              init_nxt     = 1'b1;
              state_nxt    = S_SCAN;
            end
            sapb_pkg::OP_REFRESH: begin
              cmd.load_run = 1'b1;
              init_nxt     = 1'b0;
              state_nxt    = S_SCAN;
            end
            sapb_pkg::OP_INC, sapb_pkg::OP_DEC, sapb_pkg::OP_MIN, sapb_pkg::OP_MAX,
            sapb_pkg::OP_MIN_TOG, sapb_pkg::OP_MAX_TOG, sapb_pkg::OP_CENTER: begin
              cmd.load_cmd = 1'b1;
              state_nxt    = S_CMD;
            end
            default: begin
            end
          endcase
        end
      end
      S_CMD: begin
        cmd.apply = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (status.ptr_enabled) begin
          if (init_r) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            state_nxt = S_MUL;
          end
        end else if (status.ptr_at_end) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.ptr_next = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        cmd.init_write = 1'b1;
        state_nxt      = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        cmd.emit = 1'b1;
        if (status.ptr_at_end) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.ptr_next = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

[hdl/sapb_dpath.sv]
module sapb_dpath #(
  parameter int CHANNELS      = sapb_pkg::CHANNELS_DEF,
  parameter int FRACTION_BITS = sapb_pkg::FRACTION_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  sapb_pkg::dp_cmd_t                          cmd,
  output sapb_pkg::dp_status_t                       status,
  input  logic [sapb_pkg::OP_W-1:0]                  in_operation,
  input  logic [7:0]                                 in_actuator_index,
  input  logic [CHANNELS-1:0][sapb_pkg::SET_W-1:0]   chan_settings,
  input  logic [sapb_pkg::MASK_W-1:0]                enable_mask,
  output logic                                       out_valid,
  output logic [2:0]                                 out_channel_index,
  output logic [11:0]                                out_pulse_width_us,
  output logic                                       out_last_of_run
);

  localparam int FB   = FRACTION_BITS;
  localparam int PW   = FB + 1;
  localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW   = ((PW > sapb_pkg::FIELD_W) ? PW : sapb_pkg::FIELD_W) + 1;
  localparam int PRW  = PW + 14;
  localparam int DCW  = $clog2(FB);
  localparam int ONE    = 1 << FB;
  localparam int CENTER = ONE / 2;
  localparam int LOW_TH = (2 * ONE) / 5;
  localparam int HIGH_TH = (3 * ONE + 4) / 5;

  logic [PW-1:0]               pos_r [CHANNELS];
  logic [CW-1:0]               ptr_r;
  logic [sapb_pkg::OP_W-1:0]   op_r;
  logic                        idx_ok_r;
  logic [11:0]                 rem_r;
  logic [FB-1:0]               quo_r;
  logic [DCW-1:0]              cnt_r;
  logic                        zero_r;
  logic                        big_r;
  logic signed [PRW-1:0]       prod_r;
  logic                        out_valid_r;
  logic [2:0]                  out_chan_r;
  logic [11:0]                 out_pw_r;
  logic                        out_last_r;

  logic [sapb_pkg::SET_W-1:0]      cur;
  logic [11:0]                     step, lo, hi, tr;
  logic [PW-1:0]                   pos;
  logic [PW-1:0]                   pos_nxt;
  logic                            pos_we;
  logic [sapb_pkg::MAX_CHANNELS-1:0] mask_ext;
  logic [CHANNELS-1:0]             en_vec;
  logic [CHANNELS-1:0]             above;
  logic idx_ok;
  logic signed [12:0]              n_s, d_s;
  logic [11:0]                     an, ad;
  logic [12:0]                     trial;
  logic signed [PW:0]              pos_s;
  logic signed [PRW-1:0]           bias, adj, qfull;
  logic [SW-1:0]                   sum, diff;

  assign cur  = chan_settings[ptr_r];
  assign step = cur[11:0];
  assign lo   = cur[23:12];
  assign hi   = cur[35:24];
  assign tr   = cur[47:36];
  assign pos  = pos_r[ptr_r];

  assign mask_ext = sapb_pkg::MAX_CHANNELS'(enable_mask);
  assign en_vec   = mask_ext[CHANNELS-1:0];
  assign above    = (en_vec >> 1) >> ptr_r;
  assign idx_ok   = (in_actuator_index < 8'(CHANNELS));

  assign status.ptr_enabled = en_vec[ptr_r];
  assign status.ptr_at_end  = (ptr_r == CW'(CHANNELS - 1));
  assign status.div_done    = (cnt_r == DCW'(FB - 1));

  assign n_s   = {1'b0, tr} - {1'b0, lo};
  assign d_s   = {1'b0, hi} - {1'b0, lo};
  assign an    = n_s[12] ? 12'(-n_s) : n_s[11:0];
  assign ad    = d_s[12] ? 12'(-d_s) : d_s[11:0];
  assign trial = {rem_r, 1'b0};

  assign pos_s = {1'b0, pos};
  assign bias  = prod_r[PRW-1] ? PRW'(ONE - 1) : '0;
  assign adj   = prod_r + bias;
  assign qfull = adj >>> FB;

  assign sum  = SW'(pos) + SW'(step);
  assign diff = SW'(pos) - SW'(step);

  always_comb begin
    pos_nxt = pos;
    pos_we  = 1'b0;
    if (cmd.init_write) begin
      pos_we = 1'b1;
      if (zero_r) begin
        pos_nxt = '0;
      end else if (big_r) begin
        pos_nxt = PW'(ONE);
      end else begin
        pos_nxt = {1'b0, quo_r};
      end
    end else if (cmd.apply && idx_ok_r) begin
      pos_we = 1'b1;
      case (op_r)
        sapb_pkg::OP_INC: begin
          pos_nxt = (sum > SW'(ONE)) ? PW'(ONE) : PW'(sum);
        end
        sapb_pkg::OP_DEC: begin
          pos_nxt = (SW'(pos) < SW'(step)) ? '0 : PW'(diff);
        end
        sapb_pkg::OP_MIN: begin
          pos_nxt = '0;
        end
        sapb_pkg::OP_MAX: begin
          pos_nxt = PW'(ONE);
        end
        sapb_pkg::OP_MIN_TOG: begin
          pos_nxt = (pos < PW'(LOW_TH)) ? PW'(CENTER) : '0;
        end
        sapb_pkg::OP_MAX_TOG: begin
          pos_nxt = (pos >= PW'(HIGH_TH)) ? PW'(CENTER) : PW'(ONE);
        end
        sapb_pkg::OP_CENTER: begin
          pos_nxt = PW'(CENTER);
        end
        default: begin
          pos_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_r[i] <= '0;
      end
      ptr_r       <= '0;
      op_r        <= sapb_pkg::OP_INIT;
      idx_ok_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pos_we) begin
        pos_r[ptr_r] <= pos_nxt;
      end
      if (cmd.load_cmd) begin
        op_r     <= in_operation;
        idx_ok_r <= idx_ok;
        ptr_r    <= idx_ok ? in_actuator_index[CW-1:0] : '0;
      end else if (cmd.load_run) begin
        ptr_r <= '0;
      end else if (cmd.ptr_next) begin
        ptr_r <= ptr_r + 1'b1;
      end
      if (cmd.div_start) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      zero_r <= (d_s == 13'sd0) || (n_s == 13'sd0) || (n_s[12] != d_s[12]);
      big_r  <= (an >= ad);
      rem_r  <= an;
      quo_r  <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, ad}) begin
        rem_r <= 12'(trial - {1'b0, ad});
        quo_r <= {quo_r[FB-2:0], 1'b1};
      end else begin
        rem_r <= trial[11:0];
        quo_r <= {quo_r[FB-2:0], 1'b0};
      end
    end
    if (cmd.mul_load) begin
      prod_r <= d_s * pos_s;
    end
    if (cmd.emit) begin
      out_chan_r <= 3'(ptr_r);
      out_pw_r   <= lo + qfull[11:0];
      out_last_r <= ~|above;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel_index  = out_chan_r;
  assign out_pulse_width_us = out_pw_r;
  assign out_last_of_run    = out_last_r;

endmodule

[hdl/servo_actuator_position_bank_unit.sv]
// Servo actuator position bank. Commands 1 to 7 (step, jump, toggle, center) are accepted
// when start is high and busy low, and keep busy high for one update cycle. Refresh and
// initialize walk the channels in order: a disabled channel is skipped, an enabled channel
// passes through select, multiply and output on refresh and through select, divide, write,
// multiply and output on initialize, where the position comes from a restoring divider that
// retires one quotient bit per cycle. Each result is shown for one cycle under out_valid, the
// cycle after its output step; the receiver cannot stall, so results must be taken as they
// appear. Unknown operation codes are accepted and do nothing.
module servo_actuator_position_bank_unit #(
  parameter int CHANNELS      = sapb_pkg::CHANNELS_DEF,
  parameter int FRACTION_BITS = sapb_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [sapb_pkg::OP_W-1:0]   in_operation,
  input  logic [7:0]                  in_actuator_index,
  output logic                        out_valid,
  output logic [2:0]                  out_channel_index,
  output logic [11:0]                 out_pulse_width_us,
  output logic                        out_last_of_run,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sapb_pkg::CFG_AW-1:0] paddr,
  input  logic [sapb_pkg::CFG_DW-1:0] pwdata,
  output logic [sapb_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  localparam int NUM_SLOTS = (CHANNELS > sapb_pkg::SET_REGS) ? CHANNELS : sapb_pkg::SET_REGS;

  logic [NUM_SLOTS-1:0][sapb_pkg::SET_W-1:0] settings;
  logic [sapb_pkg::MASK_W-1:0]               enable_mask;
  sapb_pkg::dp_cmd_t                         cmd;
  sapb_pkg::dp_status_t                      status;

  sapb_regs #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .settings   (settings),
    .enable_mask(enable_mask)
  );

  sapb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_operation(in_operation),
    .status      (status),
    .cmd         (cmd),
    .busy        (busy)
  );

  sapb_dpath #(
    .CHANNELS     (CHANNELS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_operation      (in_operation),
    .in_actuator_index (in_actuator_index),
    .chan_settings     (settings[CHANNELS-1:0]),
    .enable_mask       (enable_mask),
    .out_valid         (out_valid),
    .out_channel_index (out_channel_index),
    .out_pulse_width_us(out_pulse_width_us),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

[hdl/sapb_checker.sv]
module sapb_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [sapb_pkg::OP_W-1:0] in_operation,
  input logic                      out_valid,
  input logic                      out_last_of_run
);

  logic accept;
  assign accept = start && !busy;

  // a command item holds busy for its update cycle
  a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_operation >= sapb_pkg::OP_INC && in_operation <= sapb_pkg::OP_CENTER
    |=> busy)
    else $error("command item did not raise busy");

  // unknown codes leave the block idle
  a_unknown_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_operation > sapb_pkg::OP_REFRESH |=> !busy)
    else $error("unknown operation raised busy");

  // results of a run are spaced apart
  a_out_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in consecutive cycles");

  // a run with more results to come is still busy
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> busy)
    else $error("run ended before its last item");

endmodule

bind servo_actuator_position_bank_unit sapb_checker u_sapb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_operation   (in_operation),
  .out_valid      (out_valid),
  .out_last_of_run(out_last_of_run)
);
